@@ rtl/core/sbd_pkg.sv @@
// sbd_pkg: shared constants, register codes and types of the box downsampler.
// No dependencies; the divider, front, back and top modules import it.
package sbd_pkg;

   // Fixed field and register widths
   localparam int ACC_BITS       = 24;
   localparam int FACTOR_BITS    = 5;
   localparam int IN_CHANS_BITS  = 13;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int FACTOR_LIMIT   = (1 << FACTOR_BITS) - 1;

   // Register reset values
   localparam int FACTOR_RESET   = 1;
   localparam int IN_CHANS_RESET = 4096;

   // Parameter defaults
   localparam int MAX_CHANS_DEFAULT   = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int MAX_FACTOR_DEFAULT  = 16;

   // Front to back queue depth (power of two)
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TIME_FACTOR = 2'd0,
      CSR_CHAN_FACTOR = 2'd1,
      CSR_IN_CHANS    = 2'd2
   } csr_index_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/core/sbd_ram.sv @@
// sbd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sbd_divider.sv @@
// sbd_divider: two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on sbd_pkg (state and status types).
module sbd_divider #(
   parameter int NUM_BITS = 13,
   parameter int DEN_BITS = 5,
   localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_BITS-1:0]         num_a,
   input  logic [NUM_BITS-1:0]         num_b,
   input  logic [DEN_BITS-1:0]         den,
   output sbd_pkg::div_status_type     status,
   output logic [NUM_BITS-1:0]         quo_a,
   output logic [NUM_BITS-1:0]         quo_b,
   output logic [DEN_BITS-1:0]         rem_b
);

   import sbd_pkg::*;

   div_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [NUM_BITS-1:0] num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic [DEN_BITS-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;

   logic [DEN_BITS:0]   trial_a, trial_b;
   logic                ge_a, ge_b;
   logic [NUM_BITS-1:0] shift_a, shift_b;
   logic [DEN_BITS-1:0] step_rem_a, step_rem_b;

   // one restoring step per lane: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial_a    = {rem_a_ff, num_a_ff[NUM_BITS-1]};
      trial_b    = {rem_b_ff, num_b_ff[NUM_BITS-1]};
      ge_a       = trial_a >= {1'b0, den};
      ge_b       = trial_b >= {1'b0, den};
      step_rem_a = ge_a ? DEN_BITS'(trial_a - {1'b0, den}) : DEN_BITS'(trial_a);
      step_rem_b = ge_b ? DEN_BITS'(trial_b - {1'b0, den}) : DEN_BITS'(trial_b);
      shift_a    = (num_a_ff << 1) | NUM_BITS'(ge_a);
      shift_b    = (num_b_ff << 1) | NUM_BITS'(ge_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      if (start) begin
         // a restart drops any division in flight
         state_in = DIV_RUN;
         cnt_in   = '0;
         num_a_in = num_a;
         num_b_in = num_b;
         rem_a_in = '0;
         rem_b_in = '0;
      end else begin
         unique case (state_ff)
            DIV_IDLE: begin
            end
            DIV_RUN: begin
               num_a_in = shift_a;
               num_b_in = shift_b;
               rem_a_in = step_rem_a;
               rem_b_in = step_rem_b;
               cnt_in   = cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
                  state_in = DIV_IDLE;
                  done_in  = 1'b1;
               end
            end
            default: begin
               state_in = DIV_IDLE;
            end
         endcase
      end
   end

   assign status.busy = (state_ff == DIV_RUN);
   assign status.done = done_ff;
   assign quo_a       = num_a_ff;
   assign quo_b       = num_b_ff;
   assign rem_b       = rem_b_ff;

`ifndef SYNTHESIS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == DIV_RUN))
      else $error("divider done without a run");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == DIV_RUN))
      else $error("divider did not start");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) && !start |-> (rem_a_ff < den) && (rem_b_ff < den))
      else $error("partial remainder not below divisor");
`endif

endmodule

@@ rtl/core/sbd_queue.sv @@
// sbd_queue: small register FIFO between the front (classify) and back (accumulate).
// No dependencies; plain width/depth parameters.
module sbd_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop_en,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> (count_ff != '0))
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/sbd_front.sv @@
// sbd_front: config registers, channel/row position tracking, channel-group sums.
// Emits one accumulate op per closed channel group. Depends on sbd_pkg.
module sbd_front #(
   parameter int MAX_CHANS   = sbd_pkg::MAX_CHANS_DEFAULT,
   parameter int SAMPLE_BITS = sbd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_FACTOR  = sbd_pkg::MAX_FACTOR_DEFAULT,
   localparam int CHAN_BITS  = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1,
   localparam int NC_BITS    = $clog2(MAX_CHANS + 1),
   localparam int FCT_CAP    = (MAX_FACTOR < sbd_pkg::FACTOR_LIMIT) ?
                               MAX_FACTOR : sbd_pkg::FACTOR_LIMIT,
   localparam int FCT_BITS   = $clog2(FCT_CAP + 1),
   localparam int OP_BITS    = CHAN_BITS + 2 * sbd_pkg::ACC_BITS + 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sbd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sbd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_im,
   output logic                                div_start,
   output logic [NC_BITS-1:0]                  div_num_a,
   output logic [NC_BITS-1:0]                  div_num_b,
   output logic [FCT_BITS-1:0]                 div_den,
   input  sbd_pkg::div_status_type             div_status,
   input  logic [NC_BITS-1:0]                  div_quo_a,
   input  logic [NC_BITS-1:0]                  div_quo_b,
   input  logic [FCT_BITS-1:0]                 div_rem_b,
   input  logic                                q_full,
   output logic                                push_en,
   output logic [OP_BITS-1:0]                  push_data
);

   import sbd_pkg::*;

   localparam int K_BITS = (FCT_CAP > 1) ? $clog2(FCT_CAP) : 1;

   typedef struct packed {
      logic [CHAN_BITS-1:0]       oc;
      logic signed [ACC_BITS-1:0] re;
      logic signed [ACC_BITS-1:0] im;
      logic                       use_acc;
      logic                       last_row;
      logic                       row_end;
   } op_type;

   // config
   logic [FACTOR_BITS-1:0]   tf_ff, tf_in, cf_ff, cf_in;
   logic [IN_CHANS_BITS-1:0] nc_ff, nc_in;
   logic [FCT_BITS-1:0]      tf_c, cf_c;
   logic [NC_BITS-1:0]       nc_c;

   // resync after a config write
   logic start_ff, resync_ff, resync_in;

   // position state
   logic [CHAN_BITS-1:0]       chan_pos_ff, chan_pos_in, oc_ff, oc_in;
   logic [K_BITS-1:0]          k_ff, k_in, phase_ff, phase_in;
   logic [NC_BITS-1:0]         nout_ff, nout_in;
   logic signed [ACC_BITS-1:0] grp_re_ff, grp_re_in, grp_im_ff, grp_im_in;

   logic                       accept, in_range, k_last, last_row, row_done, row_end;
   logic [FCT_BITS-1:0]        ph_inc;
   logic signed [ACC_BITS-1:0] s_re, s_im, gsum_re, gsum_im;
   op_type                     op;

   // factor 0 acts as 1, above the cap acts as the cap; same for channel count
   always_comb begin
      priority if (tf_ff == '0) begin
         tf_c = FCT_BITS'(1);
      end else if (int'(tf_ff) > FCT_CAP) begin
         tf_c = FCT_BITS'(FCT_CAP);
      end else begin
         tf_c = FCT_BITS'(tf_ff);
      end
      priority if (cf_ff == '0) begin
         cf_c = FCT_BITS'(1);
      end else if (int'(cf_ff) > FCT_CAP) begin
         cf_c = FCT_BITS'(FCT_CAP);
      end else begin
         cf_c = FCT_BITS'(cf_ff);
      end
      priority if (nc_ff == '0) begin
         nc_c = NC_BITS'(1);
      end else if (int'(nc_ff) > MAX_CHANS) begin
         nc_c = NC_BITS'(MAX_CHANS);
      end else begin
         nc_c = NC_BITS'(nc_ff);
      end
   end

   always_comb begin
      tf_in = tf_ff;
      cf_in = cf_ff;
      nc_in = nc_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_FACTOR: tf_in = csr_wdata[FACTOR_BITS-1:0];
            CSR_CHAN_FACTOR: cf_in = csr_wdata[FACTOR_BITS-1:0];
            CSR_IN_CHANS:    nc_in = csr_wdata[IN_CHANS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = resync_ff || q_full;

   // classify the current sample
   always_comb begin
      s_re     = ACC_BITS'(req_sample_re);
      s_im     = ACC_BITS'(req_sample_im);
      in_range = NC_BITS'(oc_ff) < nout_ff;
      k_last   = FCT_BITS'(k_ff) == (cf_c - FCT_BITS'(1));
      ph_inc   = FCT_BITS'(phase_ff) + FCT_BITS'(1);
      last_row = ph_inc >= tf_c;
      row_done = (NC_BITS'(chan_pos_ff) + NC_BITS'(1)) >= nc_c;
      row_end  = (NC_BITS'(oc_ff) + NC_BITS'(1)) == nout_ff;
      gsum_re  = (k_ff == '0) ? s_re : grp_re_ff + s_re;
      gsum_im  = (k_ff == '0) ? s_im : grp_im_ff + s_im;
   end

   always_comb begin
      op.oc       = oc_ff;
      op.re       = gsum_re;
      op.im       = gsum_im;
      op.use_acc  = (phase_ff != '0);
      op.last_row = last_row;
      op.row_end  = row_end;
   end

   assign push_en   = accept && in_range && k_last;
   assign push_data = OP_BITS'(op);

   // position update, and reload of quotient/remainder after a resync
   always_comb begin
      chan_pos_in = chan_pos_ff;
      oc_in       = oc_ff;
      k_in        = k_ff;
      phase_in    = phase_ff;
      nout_in     = nout_ff;
      grp_re_in   = grp_re_ff;
      grp_im_in   = grp_im_ff;
      if (accept) begin
         if (in_range) begin
            grp_re_in = gsum_re;
            grp_im_in = gsum_im;
         end
         if (row_done) begin
            chan_pos_in = '0;
            oc_in       = '0;
            k_in        = '0;
            phase_in    = last_row ? '0 : K_BITS'(ph_inc);
         end else begin
            chan_pos_in = chan_pos_ff + CHAN_BITS'(1);
            if (k_last) begin
               k_in  = '0;
               oc_in = oc_ff + CHAN_BITS'(1);
            end else begin
               k_in = k_ff + K_BITS'(1);
            end
         end
      end
      if (div_status.done) begin
         nout_in = div_quo_a;
         oc_in   = CHAN_BITS'(div_quo_b);
         k_in    = K_BITS'(div_rem_b);
      end
   end

   always_comb begin
      resync_in = resync_ff;
      if (csr_we) begin
         resync_in = 1'b1;
      end else if (div_status.done) begin
         resync_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tf_ff       <= FACTOR_BITS'(FACTOR_RESET);
         cf_ff       <= FACTOR_BITS'(FACTOR_RESET);
         nc_ff       <= IN_CHANS_BITS'(IN_CHANS_RESET);
         start_ff    <= 1'b0;
         resync_ff   <= 1'b0;
         chan_pos_ff <= '0;
         oc_ff       <= '0;
         k_ff        <= '0;
         phase_ff    <= '0;
         nout_ff     <= (IN_CHANS_RESET > MAX_CHANS) ? NC_BITS'(MAX_CHANS)
                                                     : NC_BITS'(IN_CHANS_RESET);
         grp_re_ff   <= '0;
         grp_im_ff   <= '0;
      end else begin
         tf_ff       <= tf_in;
         cf_ff       <= cf_in;
         nc_ff       <= nc_in;
         start_ff    <= csr_we;
         resync_ff   <= resync_in;
         chan_pos_ff <= chan_pos_in;
         oc_ff       <= oc_in;
         k_ff        <= k_in;
         phase_ff    <= phase_in;
         nout_ff     <= nout_in;
         grp_re_ff   <= grp_re_in;
         grp_im_ff   <= grp_im_in;
      end
   end

   assign div_start = start_ff;
   assign div_num_a = nc_c;
   assign div_num_b = NC_BITS'(chan_pos_ff);
   assign div_den   = cf_c;

`ifndef SYNTHESIS
   a_write_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("input not stalled after config write");

   a_k_below_factor: assert property (@(posedge clock) disable iff (reset)
      !resync_ff |-> (FCT_BITS'(k_ff) < cf_c))
      else $error("group position not below channel factor");

   a_oc_le_pos: assert property (@(posedge clock) disable iff (reset)
      !resync_ff |-> (oc_ff <= chan_pos_ff))
      else $error("output channel beyond channel position");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> req_stall)
      else $error("input open while divider busy");
`endif

endmodule

@@ rtl/core/sbd_back.sv @@
// sbd_back: accumulator read-modify-write over the RAM, with write-to-read bypass,
// and the result output register. Depends on sbd_pkg and sbd_ram.
module sbd_back #(
   parameter int MAX_CHANS  = sbd_pkg::MAX_CHANS_DEFAULT,
   localparam int CHAN_BITS = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1,
   localparam int OP_BITS   = CHAN_BITS + 2 * sbd_pkg::ACC_BITS + 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  logic [OP_BITS-1:0]                  head_data,
   output logic                                pop_en,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sbd_pkg::ACC_BITS-1:0] rsp_sum_re,
   output logic signed [sbd_pkg::ACC_BITS-1:0] rsp_sum_im,
   output logic [CHAN_BITS-1:0]                rsp_out_chan,
   output logic                                rsp_row_end
);

   import sbd_pkg::*;

   typedef struct packed {
      logic [CHAN_BITS-1:0]       oc;
      logic signed [ACC_BITS-1:0] re;
      logic signed [ACC_BITS-1:0] im;
      logic                       use_acc;
      logic                       last_row;
      logic                       row_end;
   } op_type;

   op_type head_op;

   // execute stage: op plus captured bypass
   logic                       rd_valid_ff, rd_valid_in;
   op_type                     rd_op_ff;
   logic                       byp_ff;
   logic signed [ACC_BITS-1:0] byp_re_ff, byp_im_ff;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic signed [ACC_BITS-1:0] out_re_ff, out_im_ff;
   logic [CHAN_BITS-1:0]       out_chan_ff;
   logic                       out_row_end_ff;

   logic [2*ACC_BITS-1:0]      ram_q;
   logic signed [ACC_BITS-1:0] acc_re, acc_im, sum_re, sum_im;
   logic                       wr_en, out_free, out_load, rd_adv, byp_in;

   assign head_op = op_type'(head_data);

   always_comb begin
      acc_re   = byp_ff ? byp_re_ff : ram_q[2*ACC_BITS-1:ACC_BITS];
      acc_im   = byp_ff ? byp_im_ff : ram_q[ACC_BITS-1:0];
      sum_re   = rd_op_ff.re + (rd_op_ff.use_acc ? acc_re : '0);
      sum_im   = rd_op_ff.im + (rd_op_ff.use_acc ? acc_im : '0);
      wr_en    = rd_valid_ff && !rd_op_ff.last_row;
      out_free = !out_valid_ff || !rsp_stall;
      out_load = rd_valid_ff && rd_op_ff.last_row && out_free;
      rd_adv   = !rd_valid_ff || !rd_op_ff.last_row || out_free;
      pop_en   = head_valid && rd_adv;
      // the RAM read issued now misses the write landing at this edge
      byp_in   = wr_en && (rd_op_ff.oc == head_op.oc);
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (rd_adv) begin
         rd_valid_in = pop_en;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop_en) begin
         rd_op_ff  <= head_op;
         byp_ff    <= byp_in;
         byp_re_ff <= sum_re;
         byp_im_ff <= sum_im;
      end
      if (out_load) begin
         out_re_ff      <= sum_re;
         out_im_ff      <= sum_im;
         out_chan_ff    <= rd_op_ff.oc;
         out_row_end_ff <= rd_op_ff.row_end;
      end
   end

   sbd_ram #(
      .WIDTH (2 * ACC_BITS),
      .DEPTH (MAX_CHANS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_op_ff.oc),
      .wr_data ({sum_re, sum_im}),
      .rd_en   (pop_en),
      .rd_addr (head_op.oc),
      .rd_data (ram_q)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_sum_re   = out_re_ff;
   assign rsp_sum_im   = out_im_ff;
   assign rsp_out_chan = out_chan_ff;
   assign rsp_row_end  = out_row_end_ff;

`ifndef SYNTHESIS
   a_result_from_last_row: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(rd_valid_ff && rd_op_ff.last_row))
      else $error("result without a last-row op");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && rd_op_ff.last_row && !out_free |=> rd_valid_ff && $stable(rd_op_ff))
      else $error("blocked op lost from execute stage");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> head_valid)
      else $error("pop without queued op");
`endif

endmodule

@@ rtl/core/spectrogram_box_downsampler_core.sv @@
// spectrogram_box_downsampler_core: top level of the time/frequency box-sum decimator.
// Depends on sbd_pkg, sbd_front, sbd_divider, sbd_queue, sbd_back, sbd_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  req     | req_valid/req_stall  | req_sample_re, req_sample_im (signed samples)
//  rsp     | rsp_valid/rsp_stall  | rsp_sum_re, rsp_sum_im, rsp_out_chan, rsp_row_end
//  csr     | csr_we (no wait)     | csr_index, csr_wdata
//
// Throughput: one sample per clock while req_stall is low; set by the single accumulator RAM
//   read-modify-write per closed channel group (one read and one write port).
// A closing sample's sum reaches rsp through the op queue, execute stage and output register.
// After any csr write, req stalls while the divider recomputes
//   output-channel count and group position.
// Reset: synchronous, active high; config returns to time/chan factor 1, 4096 chans.
// A stalled rsp fills the 4-entry op queue, then backs up to req_stall.

module spectrogram_box_downsampler_core #(
   parameter int MAX_CHANS   = sbd_pkg::MAX_CHANS_DEFAULT,
   parameter int SAMPLE_BITS = sbd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_FACTOR  = sbd_pkg::MAX_FACTOR_DEFAULT,
   localparam int CHAN_BITS  = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   // config write port
   input  logic                                csr_we,
   input  logic [sbd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sbd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // sample input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_im,
   // box sums out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sbd_pkg::ACC_BITS-1:0] rsp_sum_re,
   output logic signed [sbd_pkg::ACC_BITS-1:0] rsp_sum_im,
   output logic [CHAN_BITS-1:0]                rsp_out_chan,
   output logic                                rsp_row_end
);

   import sbd_pkg::*;

   localparam int NC_BITS  = $clog2(MAX_CHANS + 1);
   localparam int FCT_CAP  = (MAX_FACTOR < FACTOR_LIMIT) ? MAX_FACTOR : FACTOR_LIMIT;
   localparam int FCT_BITS = $clog2(FCT_CAP + 1);
   localparam int OP_BITS  = CHAN_BITS + 2 * ACC_BITS + 3;

   // front <-> divider
   logic                div_start;
   logic [NC_BITS-1:0]  div_num_a, div_num_b, div_quo_a, div_quo_b;
   logic [FCT_BITS-1:0] div_den, div_rem_b;
   div_status_type      div_status;

   // front -> queue -> back
   logic               push_en, q_full, pop_en, head_valid;
   logic [OP_BITS-1:0] push_data, head_data;

   // Front: config, position counters, group sums; one op per closed group.
   sbd_front #(
      .MAX_CHANS   (MAX_CHANS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_FACTOR  (MAX_FACTOR)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .div_start     (div_start),
      .div_num_a     (div_num_a),
      .div_num_b     (div_num_b),
      .div_den       (div_den),
      .div_status    (div_status),
      .div_quo_a     (div_quo_a),
      .div_quo_b     (div_quo_b),
      .div_rem_b     (div_rem_b),
      .q_full        (q_full),
      .push_en       (push_en),
      .push_data     (push_data)
   );

   // Divider: in_chans/chan_factor and chan_pos/chan_factor after config writes.
   sbd_divider #(
      .NUM_BITS (NC_BITS),
      .DEN_BITS (FCT_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_a  (div_num_a),
      .num_b  (div_num_b),
      .den    (div_den),
      .status (div_status),
      .quo_a  (div_quo_a),
      .quo_b  (div_quo_b),
      .rem_b  (div_rem_b)
   );

   // Op queue decouples sample intake from accumulate/output back-pressure.
   sbd_queue #(
      .WIDTH (OP_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .full      (q_full),
      .pop_en    (pop_en),
      .pop_valid (head_valid),
      .pop_data  (head_data)
   );

   // Back: accumulator RMW across rows, result register on the last row.
   sbd_back #(
      .MAX_CHANS (MAX_CHANS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop_en       (pop_en),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sum_re   (rsp_sum_re),
      .rsp_sum_im   (rsp_sum_im),
      .rsp_out_chan (rsp_out_chan),
      .rsp_row_end  (rsp_row_end)
   );

endmodule

@@ verif/spectrogram_box_downsampler_core_test.sv @@
// Self-checking testbench for spectrogram_box_downsampler_core: directed corner cases,
// then random configurations and samples, checked against an in-bench box-sum predictor.
// Depends on sbd_pkg and the core RTL only.
module spectrogram_box_downsampler_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbd_pkg::*;

   localparam int MAX_CHANS   = MAX_CHANS_DEFAULT;
   localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
   localparam int MAX_FACTOR  = MAX_FACTOR_DEFAULT;
   localparam int CHAN_BITS   = $clog2(MAX_CHANS);
   localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on any port
   localparam int LONG_HOLD   = 300;    // receiver hold-off that backs up into req_stall
   localparam int SETTLE      = 8;      // margin for words that close no group to drain

   typedef struct {
      logic [SAMPLE_BITS-1:0] re;
      logic [SAMPLE_BITS-1:0] im;
   } sample_word_type;

   typedef struct {
      logic [ACC_BITS-1:0]  re;
      logic [ACC_BITS-1:0]  im;
      logic [CHAN_BITS-1:0] chan;
      logic                 row_end;
   } box_sum_type;

   // ---------------------------------------------------------------- DUT ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_re = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_im = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [ACC_BITS-1:0]    rsp_sum_re;
   logic signed [ACC_BITS-1:0]    rsp_sum_im;
   logic [CHAN_BITS-1:0]          rsp_out_chan;
   logic                          rsp_row_end;

   spectrogram_box_downsampler_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_re    (rsp_sum_re),
      .rsp_sum_im    (rsp_sum_im),
      .rsp_out_chan  (rsp_out_chan),
      .rsp_row_end   (rsp_row_end)
   );

   // ---------------------------------------------------------------- shared bench state
   sample_word_type pending_samples[$];   // filled by the sequence, drained by the driver
   box_sum_type     sums_due[$];          // predicted box sums, oldest first

   int  idle_odds      = 0;    // 1-in-N chance per cycle of starting an idle burst; 0 = none
   bit  long_hold_req  = 1'b0; // asks the receiver for one long hold-off
   int  mismatch_count = 0;
   int  sums_checked   = 0;
   int  samples_taken  = 0;
   int  configs_run    = 0;

   // Predictor copy of the registers and of the core's state
   logic [FACTOR_BITS-1:0]   cfg_time_factor = FACTOR_BITS'(FACTOR_RESET);
   logic [FACTOR_BITS-1:0]   cfg_chan_factor = FACTOR_BITS'(FACTOR_RESET);
   logic [IN_CHANS_BITS-1:0] cfg_in_chans    = IN_CHANS_BITS'(IN_CHANS_RESET);
   int row_acc_re[MAX_CHANS];
   int row_acc_im[MAX_CHANS];
   int group_re   = 0;
   int group_im   = 0;
   int chan_pos   = 0;
   int time_phase = 0;

   // ---------------------------------------------------------------- clock
   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   // Factor 0 behaves as 1, anything above the limit as the limit.
   function automatic int eff_factor(input int f);
      if (f == 0) return 1;
      if (f > MAX_FACTOR) return MAX_FACTOR;
      return f;
   endfunction

   function automatic int eff_chans(input int n);
      if (n == 0) return 1;
      if (n > MAX_CHANS) return MAX_CHANS;
      return n;
   endfunction

   // Advance the box-sum state by one sample; queue a sum when the sample
   // closes a channel group on the last row of a time group.
   task automatic predict_box_sum(input logic signed [SAMPLE_BITS-1:0] re,
                                  input logic signed [SAMPLE_BITS-1:0] im);
      int          tf, cf, nc, nout, oc, k, vr, vi;
      bit          last_row;
      box_sum_type sum;
      tf       = eff_factor(cfg_time_factor);
      cf       = eff_factor(cfg_chan_factor);
      nc       = eff_chans(cfg_in_chans);
      nout     = nc / cf;
      last_row = (time_phase + 1 >= tf);   // a phase past the end counts as the last row
      oc       = chan_pos / cf;
      k        = chan_pos % cf;
      if (oc < nout) begin
         if (k == 0) begin
            group_re = re;
            group_im = im;
         end else begin
            group_re += re;
            group_im += im;
         end
         if (k == cf - 1) begin
            vr = group_re;
            vi = group_im;
            if (time_phase != 0) begin
               vr += row_acc_re[oc];
               vi += row_acc_im[oc];
            end
            if (last_row) begin
               sum.re      = vr[ACC_BITS-1:0];
               sum.im      = vi[ACC_BITS-1:0];
               sum.chan    = oc[CHAN_BITS-1:0];
               sum.row_end = (oc + 1 == nout);
               sums_due.push_back(sum);
            end else begin
               row_acc_re[oc] = vr;
               row_acc_im[oc] = vi;
            end
         end
      end
      // channels past the last whole group are dropped but still end the row
      if (chan_pos + 1 >= nc) begin
         chan_pos   = 0;
         time_phase = last_row ? 0 : time_phase + 1;
      end else begin
         chan_pos++;
      end
   endtask

   // ---------------------------------------------------------------- sample driver
   int              gap_left = 0;
   sample_word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_box_sum(req_sample_re, req_sample_im);
            samples_taken++;
         end
         // a stalled word stays put; otherwise pick idle or the next word
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
               gap_left  = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               next_word = pending_samples.pop_front();
               req_valid     <= 1'b1;
               req_sample_re <= next_word.re;
               req_sample_im <= next_word.im;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver stall
   int stall_left     = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left     = 0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
         end else if (stall_left == 0 && idle_odds != 0 &&
                      $urandom_range(0, idle_odds - 1) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- sum checker
   box_sum_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sums_due.size() == 0) begin
            $error("unexpected box sum: chan %0d re %0d im %0d",
                   rsp_out_chan, rsp_sum_re, rsp_sum_im);
            mismatch_count++;
         end else begin
            oldest = sums_due.pop_front();
            sums_checked++;
            if (rsp_sum_re !== oldest.re) begin
               $error("sum_re: expected %0d, got %0d", $signed(oldest.re), rsp_sum_re);
               mismatch_count++;
            end
            if (rsp_sum_im !== oldest.im) begin
               $error("sum_im: expected %0d, got %0d", $signed(oldest.im), rsp_sum_im);
               mismatch_count++;
            end
            if (rsp_out_chan !== oldest.chan) begin
               $error("out_chan: expected %0d, got %0d", oldest.chan, rsp_out_chan);
               mismatch_count++;
            end
            if (rsp_row_end !== oldest.row_end) begin
               $error("row_end: expected %0d, got %0d", oldest.row_end, rsp_row_end);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d sums outstanding",
                     QUIET_LIMIT, sums_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence helpers
   task automatic write_reg(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      case (idx)
         CSR_TIME_FACTOR: cfg_time_factor = value[FACTOR_BITS-1:0];
         CSR_CHAN_FACTOR: cfg_chan_factor = value[FACTOR_BITS-1:0];
         CSR_IN_CHANS:    cfg_in_chans    = value[IN_CHANS_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input int tf, input int cf, input int nc);
      write_reg(CSR_TIME_FACTOR, tf);
      write_reg(CSR_CHAN_FACTOR, cf);
      write_reg(CSR_IN_CHANS, nc);
      configs_run++;
   endtask

   // Queue one word; called only right after a falling edge.
   task automatic queue_sample(input logic [SAMPLE_BITS-1:0] re,
                               input logic [SAMPLE_BITS-1:0] im);
      sample_word_type w;
      w.re = re;
      w.im = im;
      pending_samples.push_back(w);
   endtask

   // Mostly uniform, with full-scale values mixed in.
   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int count);
      @(negedge clock);
      repeat (count) queue_sample(rand_sample(), rand_sample());
   endtask

   // Wait until every word is taken and every sum is back, then let the
   // pipeline drain words that close no group.
   task automatic settle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || sums_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int pick_factor();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 4);
      return $urandom_range(0, 31);   // includes zero and out-of-range factors
   endfunction

   function automatic int pick_chans();
      case ($urandom_range(0, 9))
         8:       return $urandom_range(0, 4);
         9:       return $urandom_range(25, 64);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   // ---------------------------------------------------------------- main sequence
   int tf_val, cf_val, nc_val, span, random_words;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 4;

      // Reset settings pass samples through; full-scale and sign corners.
      @(negedge clock);
      queue_sample(16'h7fff, 16'h8000);
      queue_sample(16'h8000, 16'h7fff);
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'hffff, 16'h0001);
      settle();

      // Shrink the row while mid-row: position is past the end, so the next
      // word is dropped and closes the row.
      write_reg(CSR_IN_CHANS, 2);
      queue_random(3);
      settle();

      // Zero factors and zero channel count all act as 1.
      configure(0, 0, 0);
      queue_random(2);
      settle();

      // Oversized channel factor and fewer channels than one group: no sums.
      configure(1, 20, 3);
      queue_random(3);
      settle();

      // Shorten the time group after two of four rows: the third row is last.
      configure(4, 2, 4);
      queue_random(8);
      settle();
      write_reg(CSR_TIME_FACTOR, 2);
      queue_random(4);
      settle();

      // Pass-through rows while the receiver holds off, so the core backs up.
      configure(1, 1, 16);
      @(negedge clock);
      long_hold_req = 1'b1;
      repeat (48) queue_sample(rand_sample(), rand_sample());
      settle();

      // Random settings, whole time groups each time so no partial sum leaks
      // across a register change.
      random_words = 48;
      while (random_words < 280) begin
         do begin
            tf_val = pick_factor();
            cf_val = pick_factor();
            nc_val = pick_chans();
         end while (eff_factor(tf_val) * eff_chans(nc_val) > 64);
         case ($urandom_range(0, 2))
            0:       idle_odds = 0;
            1:       idle_odds = 3;
            default: idle_odds = 12;
         endcase
         span = eff_factor(tf_val) * eff_chans(nc_val) * $urandom_range(1, 2);
         configure(tf_val, cf_val, nc_val);
         queue_random(span);
         random_words += span;
         settle();
      end

      // Final stretch without idling: an oversized channel factor over a
      // 16-channel row, the longest time group on a short row, then a
      // channel count above the limit.
      idle_odds = 0;
      configure(4, 31, 16);
      queue_random(4 * 16);
      settle();
      configure(31, 1, 2);
      queue_random(MAX_FACTOR * 2);
      settle();
      configure(1, 1, 8191);
      queue_random(16);
      settle();

      $display("Ran %0d register settings over %0d samples; %0d box sums checked.",
               configs_run, samples_taken, sums_checked);
      if (mismatch_count == 0 && sums_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/sbd_pkg.sv
rtl/core/sbd_ram.sv
rtl/core/sbd_divider.sv
rtl/core/sbd_queue.sv
rtl/core/sbd_front.sv
rtl/core/sbd_back.sv
rtl/core/spectrogram_box_downsampler_core.sv
verif/spectrogram_box_downsampler_core_test.sv
